@@ hdl/btrf_pkg.sv @@
// types and constants shared by the below-threshold run finder
package btrf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 17;
  localparam int COUNT_W  = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [COUNT_W-1:0]         count_t;

  localparam sample_t THRESHOLD_RESET = 16'sd800;
  localparam pos_t    POS_MAX         = '1;
  localparam count_t  COUNT_MAX       = '1;

  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int CMD_DEPTH = 2;

  // one command from the classifier to the reporting side
  typedef struct packed {
    logic do_close;
    pos_t run_first;
    pos_t run_last;
    logic do_summary;
  } cmd_t;

endpackage

@@ hdl/btrf_sample_if.sv @@
// sample channel: valid, ready and one sample with its end-of-set flag
interface btrf_sample_if;
  import btrf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    final_sample;

  modport source (output valid, sample, final_sample, input ready);
  modport sink   (input valid, sample, final_sample, output ready);
endinterface

@@ hdl/btrf_result_if.sv @@
// result channel: valid, ready and one run report or summary
interface btrf_result_if;
  import btrf_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  pos_t   run_start;
  pos_t   run_end;
  pos_t   gap_before;
  count_t run_count;
  logic   has_pair;
  pos_t   pair_first_start;
  pos_t   pair_first_end;
  pos_t   pair_second_start;
  pos_t   pair_second_end;
  logic   last_result;

  modport source (output valid, kind, run_start, run_end, gap_before, run_count, has_pair,
                  pair_first_start, pair_first_end, pair_second_start, pair_second_end,
                  last_result, input ready);
  modport sink   (input valid, kind, run_start, run_end, gap_before, run_count, has_pair,
                  pair_first_start, pair_first_end, pair_second_start, pair_second_end,
                  last_result, output ready);
endinterface

@@ hdl/below_threshold_run_finder_top.sv @@
// top level of the below-threshold run finder
//
//  channel   dir  width  beat
//  samples   in   17     sample (signed 16), final_sample
//  results   out  138    run report or end-of-set summary
//  cfg       in   16     threshold write, no read-back
//
// one sample is taken per cycle while the queue has room, classified in that cycle
// each run close or set end becomes one command in a two-entry queue
// the back end turns a command into one result beat per cycle while results are
// taken, two beats when a closing run and the set end come with the same sample
// rst is synchronous: threshold returns to 800, all run state clears
// a stalled result register holds its beat while samples keep flowing
// until the command queue fills
module below_threshold_run_finder_top #(
  parameter int unsigned MAX_SAMPLES = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  btrf_pkg::sample_t  cfg_data,
  btrf_sample_if.sink        samples,
  btrf_result_if.source      results
);
  import btrf_pkg::*;

  // positions saturate at MAX_SAMPLES, clamped to the 17-bit field limit
  localparam int unsigned LIMIT_INT = (MAX_SAMPLES < 32'h1FFFF) ? MAX_SAMPLES : 32'h1FFFF;
  localparam logic [16:0] POS_LIMIT = LIMIT_INT[16:0];

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_valid;

  // front end: threshold register and run detection
  btrf_front #(
    .POS_LIMIT (POS_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .cmd       (front_cmd),
    .cmd_push  (cmd_push),
    .cmd_full  (cmd_full)
  );

  // decouples classification from result delivery
  btrf_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (front_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (back_cmd),
    .not_empty (cmd_valid)
  );

  // back end: gap tracking, run counting, result register
  btrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .results   (results)
  );

endmodule

@@ hdl/btrf_front.sv @@
// front end: threshold compare, position count and run open/close detection
module btrf_front #(
  parameter logic [16:0] POS_LIMIT = 17'd65535
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  btrf_pkg::sample_t     cfg_data,
  btrf_sample_if.sink           samples,
  output btrf_pkg::cmd_t        cmd,
  output logic                  cmd_push,
  input  logic                  cmd_full
);
  import btrf_pkg::*;

  sample_t threshold;
  pos_t    sample_index;
  logic    in_run;
  pos_t    current_start;

  pos_t    sample_index_next;
  logic    in_run_next;
  pos_t    current_start_next;
  pos_t    pos;
  logic    accept;
  logic    below;
  logic    close_high;
  logic    close_final;

  assign samples.ready = !cmd_full;
  assign accept        = samples.valid && !cmd_full;
  assign pos           = sample_index + pos_t'(1);
  assign below         = samples.sample <= threshold;

  always_comb begin
    sample_index_next  = sample_index;
    in_run_next        = in_run;
    current_start_next = current_start;
    close_high         = 1'b0;
    if (sample_index < POS_LIMIT) begin
      sample_index_next = pos;
      if (below) begin
        if (!in_run) begin
          in_run_next        = 1'b1;
          current_start_next = pos;
        end
      end else if (in_run) begin
        in_run_next = 1'b0;
        close_high  = 1'b1;
      end
    end
    close_final = samples.final_sample && in_run_next;
  end

  // a high sample and the end of the set never both close a run
  assign cmd.do_close   = close_high || close_final;
  assign cmd.run_first  = current_start_next;
  assign cmd.run_last   = close_high ? sample_index : sample_index_next;
  assign cmd.do_summary = samples.final_sample;
  assign cmd_push       = accept && (cmd.do_close || samples.final_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      in_run        <= 1'b0;
      current_start <= '0;
    end else if (accept) begin
      if (samples.final_sample) begin
        sample_index  <= '0;
        in_run        <= 1'b0;
        current_start <= '0;
      end else begin
        sample_index  <= sample_index_next;
        in_run        <= in_run_next;
        current_start <= current_start_next;
      end
    end
  end

endmodule

@@ hdl/btrf_cmd_queue.sv @@
// small command queue between front and back end
module btrf_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  btrf_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output btrf_pkg::cmd_t  pop_data,
  output logic            not_empty
);
  import btrf_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             slots [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(CMD_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/btrf_back.sv @@
// back end: run bookkeeping, closest-pair tracking and result register
module btrf_back (
  input  logic            clk,
  input  logic            rst,
  input  btrf_pkg::cmd_t  cmd,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  btrf_result_if.source   results
);
  import btrf_pkg::*;

  count_t runs_found;
  pos_t   previous_start;
  pos_t   previous_end;
  pos_t   smallest_gap;
  pos_t   best_pair_bounds [4];
  logic   phase;

  logic   load;
  logic   emit_report;
  logic   has_prev;
  pos_t   gap_raw;
  pos_t   gap;
  logic   better;
  count_t runs_found_next;
  logic   pair_ok;

  assign load            = cmd_valid && (!results.valid || results.ready);
  assign emit_report     = cmd.do_close && !phase;
  assign has_prev        = runs_found != '0;
  assign gap_raw         = cmd.run_first - previous_end;
  assign gap             = has_prev ? gap_raw : '0;
  assign better          = has_prev && (gap_raw < smallest_gap);
  assign runs_found_next = (runs_found == COUNT_MAX) ? runs_found : runs_found + count_t'(1);
  assign pair_ok         = runs_found >= count_t'(2);
  // a close followed by a summary holds its command for a second beat
  assign cmd_pop         = load && !(emit_report && cmd.do_summary);

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid  <= 1'b0;
      phase          <= 1'b0;
      runs_found     <= '0;
      previous_start <= '0;
      previous_end   <= '0;
      smallest_gap   <= POS_MAX;
      for (int i = 0; i < 4; i++) begin
        best_pair_bounds[i] <= '0;
      end
    end else begin
      results.valid <= load || (results.valid && !results.ready);
      if (load) begin
        if (emit_report) begin
          if (better) begin
            smallest_gap        <= gap_raw;
            best_pair_bounds[0] <= previous_start;
            best_pair_bounds[1] <= previous_end;
            best_pair_bounds[2] <= cmd.run_first;
            best_pair_bounds[3] <= cmd.run_last;
          end
          previous_start <= cmd.run_first;
          previous_end   <= cmd.run_last;
          runs_found     <= runs_found_next;
          phase          <= cmd.do_summary;
        end else begin
          phase          <= 1'b0;
          runs_found     <= '0;
          previous_start <= '0;
          previous_end   <= '0;
          smallest_gap   <= POS_MAX;
          for (int i = 0; i < 4; i++) begin
            best_pair_bounds[i] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_report) begin
        results.kind              <= KIND_REPORT;
        results.run_start         <= cmd.run_first;
        results.run_end           <= cmd.run_last;
        results.gap_before        <= gap;
        results.run_count         <= runs_found_next;
        results.has_pair          <= 1'b0;
        results.pair_first_start  <= '0;
        results.pair_first_end    <= '0;
        results.pair_second_start <= '0;
        results.pair_second_end   <= '0;
        results.last_result       <= !cmd.do_summary;
      end else begin
        results.kind              <= KIND_SUMMARY;
        results.run_start         <= '0;
        results.run_end           <= '0;
        results.gap_before        <= '0;
        results.run_count         <= runs_found;
        results.has_pair          <= pair_ok;
        results.pair_first_start  <= pair_ok ? best_pair_bounds[0] : '0;
        results.pair_first_end    <= pair_ok ? best_pair_bounds[1] : '0;
        results.pair_second_start <= pair_ok ? best_pair_bounds[2] : '0;
        results.pair_second_end   <= pair_ok ? best_pair_bounds[3] : '0;
        results.last_result       <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_summary_is_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.kind == KIND_SUMMARY) |-> results.last_result)
    else $error("summary beat without last_result");

  a_phase_holds_cmd: assert property (@(posedge clk) disable iff (rst)
    phase |-> cmd_valid && cmd.do_close && cmd.do_summary)
    else $error("second beat pending without a close-and-summary command");

  a_gap_idle: assert property (@(posedge clk) disable iff (rst)
    (runs_found < count_t'(2)) |-> (smallest_gap == POS_MAX))
    else $error("smallest gap moved before two runs exist");

  a_split_beat: assert property (@(posedge clk) disable iff (rst)
    load && emit_report && cmd.do_summary |=> phase)
    else $error("close-and-summary command popped after its first beat");
`endif

endmodule
